// ===== design/fdns_pkg.sv =====
// Shared types and fixed widths for the face normal and shading pipeline.
`default_nettype none
package fdns_pkg;
  // Normalized cross component width: top set bit of the largest lands at bit 30.
  localparam int MW    = 31;
  // Square root result width and width of the sum of squares.
  localparam int RW    = 32;
  localparam int SW    = 64;
  // Quotient bits of each normal component, before the sign.
  localparam int QW    = 15;
  // Light register and normal component width.
  localparam int LW    = 16;
  // Number of steps in one normal divider.
  localparam int DIVL  = QW + 1;
  localparam int ONE_Q15 = 32768;
  localparam int ROUND_Q14 = 8192;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_LIGHT_X = 2'd0;
  localparam logic [1:0] REG_LIGHT_Y = 2'd1;
  localparam logic [1:0] REG_LIGHT_Z = 2'd2;

  // Data that travels beside the length computation.
  typedef struct packed {
    logic                degen;
    logic [2:0]          neg;
    logic [2:0][MW-1:0]  m;
  } side_t;
endpackage
`default_nettype wire

// ===== design/fdns_cross.sv =====
// Edge, cross product and normalizing shift stages.
`default_nettype none
module fdns_cross #(
  parameter int CW = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 vld_in,
  input  wire logic [8:0][CW-1:0]   v_in,
  output logic                      vld_out,
  output fdns_pkg::side_t           side_out
);
  import fdns_pkg::*;

  localparam int EW  = CW + 1;
  localparam int PW  = 2 * EW;
  localparam int XW  = PW + 1;
  localparam int LMW = $clog2(XW + 1);

  logic [6:0] vld_r;
  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic signed [PW-1:0] prod_r [6];
  logic signed [XW-1:0] x_r [3];
  logic [XW-1:0] mag4_r [3];
  logic [2:0]    neg4_r;
  logic [XW-1:0] mag5_r [3];
  logic [2:0]    neg5_r;
  logic [XW-1:0] or5_r;
  logic [XW-1:0] mag6_r [3];
  logic [2:0]    neg6_r;
  logic [LMW-1:0] lmax6_r;
  logic [LMW-1:0] lmax_nxt;
  side_t side_r;

  // Valid bits travel with the data; the pipe never stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], vld_in};
    end
  end

  // Leading one position of the OR of the three magnitudes.
  always_comb begin
    lmax_nxt = '0;
    for (int j = 0; j < XW; j++) begin
      if (or5_r[j]) lmax_nxt = LMW'(j + 1);
    end
  end

  always_ff @(posedge clk) begin
    // Edges from the first vertex.
    for (int i = 0; i < 3; i++) begin
      e1_r[i] <= $signed({v_in[3+i][CW-1], v_in[3+i]}) - $signed({v_in[i][CW-1], v_in[i]});
      e2_r[i] <= $signed({v_in[6+i][CW-1], v_in[6+i]}) - $signed({v_in[i][CW-1], v_in[i]});
    end
    // The six partial products of the cross product.
    prod_r[0] <= e1_r[1] * e2_r[2];
    prod_r[1] <= e1_r[2] * e2_r[1];
    prod_r[2] <= e1_r[2] * e2_r[0];
    prod_r[3] <= e1_r[0] * e2_r[2];
    prod_r[4] <= e1_r[0] * e2_r[1];
    prod_r[5] <= e1_r[1] * e2_r[0];
    // Exact cross components.
    for (int i = 0; i < 3; i++) begin
      x_r[i] <= $signed({prod_r[2*i][PW-1], prod_r[2*i]})
              - $signed({prod_r[2*i+1][PW-1], prod_r[2*i+1]});
    end
    // Sign and magnitude.
    for (int i = 0; i < 3; i++) begin
      neg4_r[i] <= x_r[i][XW-1];
      mag4_r[i] <= x_r[i][XW-1] ? XW'(-x_r[i]) : XW'(x_r[i]);
    end
    // Combined bit pattern for the length search.
    mag5_r <= mag4_r;
    neg5_r <= neg4_r;
    or5_r  <= mag4_r[0] | mag4_r[1] | mag4_r[2];
    mag6_r  <= mag5_r;
    neg6_r  <= neg5_r;
    lmax6_r <= lmax_nxt;
    // One shift puts the top set bit of the largest magnitude at bit 30.
    side_r.degen <= (lmax6_r == '0);
    side_r.neg   <= neg6_r;
    for (int i = 0; i < 3; i++) begin
      side_r.m[i] <= MW'({mag6_r[i], {MW{1'b0}}} >> lmax6_r);
    end
  end

  assign vld_out  = vld_r[6];
  assign side_out = side_r;
endmodule
`default_nettype wire

// ===== design/fdns_isqrt.sv =====
// Pipelined integer square root, two radicand bits a stage, with side data.
`default_nettype none
module fdns_isqrt (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     vld_in,
  input  wire logic [fdns_pkg::SW-1:0]  sum_in,
  input  wire fdns_pkg::side_t          side_in,
  output logic                          vld_out,
  output logic [fdns_pkg::RW-1:0]       root_out,
  output fdns_pkg::side_t               side_out
);
  import fdns_pkg::*;

  localparam int REMW = RW + 3;

  logic [RW-1:0]   vld_r;
  logic [REMW-1:0] rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [SW-1:0]   n_r    [RW];
  side_t           side_r [RW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[RW-2:0], vld_in};
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [REMW-1:0] rem_i;
    logic [RW-1:0]   root_i;
    logic [SW-1:0]   n_i;
    side_t           side_i;
    logic [REMW-1:0] rem_s;
    logic [REMW-1:0] trial;

    // Stage input comes from the port or from the previous stage.
    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign n_i    = sum_in;
      assign side_i = side_in;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign n_i    = n_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign rem_s = {rem_i[REMW-3:0], n_i[SW-1:SW-2]};
    assign trial = {1'b0, root_i, 2'b01};

    // One restoring step: try the next root bit.
    always_ff @(posedge clk) begin
      if (rem_s >= trial) begin
        rem_r[k]  <= rem_s - trial;
        root_r[k] <= {root_i[RW-2:0], 1'b1};
      end else begin
        rem_r[k]  <= rem_s;
        root_r[k] <= {root_i[RW-2:0], 1'b0};
      end
      n_r[k]    <= {n_i[SW-3:0], 2'b00};
      side_r[k] <= side_i;
    end
  end

  assign vld_out  = vld_r[RW-1];
  assign root_out = root_r[RW-1];
  assign side_out = side_r[RW-1];
endmodule
`default_nettype wire

// ===== design/fdns_div.sv =====
// Pipelined rounded divider for one normal component, one quotient bit a stage.
`default_nettype none
module fdns_div (
  input  wire logic                    clk,
  input  wire logic [fdns_pkg::MW-1:0] m_in,
  input  wire logic [fdns_pkg::RW-1:0] len_in,
  output logic [fdns_pkg::QW-1:0]      q_out
);
  import fdns_pkg::*;

  localparam int DW = RW + 1;

  logic [DW-1:0] rem_r [DIVL];
  logic [DW-1:0] den_r [DIVL];
  logic [QW-1:0] low_r [DIVL];
  logic [QW-1:0] q_r   [DIVL];

  // The dividend is m * 2^15 + len; its upper part starts the remainder.
  always_ff @(posedge clk) begin
    rem_r[0] <= DW'(m_in) + DW'(len_in >> QW);
    den_r[0] <= {len_in, 1'b0};
    low_r[0] <= len_in[QW-1:0];
    q_r[0]   <= '0;
  end

  for (genvar k = 1; k < DIVL; k++) begin : g_step
    logic [DW:0] rs;
    assign rs = {rem_r[k-1], low_r[k-1][QW-1]};

    // Bring in the next dividend bit and subtract when it fits.
    always_ff @(posedge clk) begin
      if (rs >= {1'b0, den_r[k-1]}) begin
        rem_r[k] <= DW'(rs - {1'b0, den_r[k-1]});
        q_r[k]   <= {q_r[k-1][QW-2:0], 1'b1};
      end else begin
        rem_r[k] <= DW'(rs);
        q_r[k]   <= {q_r[k-1][QW-2:0], 1'b0};
      end
      den_r[k] <= den_r[k-1];
      low_r[k] <= {low_r[k-1][QW-2:0], 1'b0};
    end
  end

  assign q_out = q_r[DIVL-1];
endmodule
`default_nettype wire

// ===== design/face_normal_diffuse_shade.sv =====
// Face normal and half-Lambert shading pipeline top level.
// Throughput: one item per cycle; busy stays low, so start may be high every cycle.
// Most of the depth lies in the 32-stage square root and the 16-stage normal dividers.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Synchronous active-low reset clears all valid bits and loads the default light.
`default_nettype none
module face_normal_diffuse_shade #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_a_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_b_z,
  input  wire logic signed [COORD_WIDTH-1:0] in_c_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_c_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_c_z,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_idx,
  input  wire logic [15:0]                   cfg_data,
  output logic                               out_valid,
  output logic signed [15:0]                 out_norm_x,
  output logic signed [15:0]                 out_norm_y,
  output logic signed [15:0]                 out_norm_z,
  output logic [15:0]                        out_shade,
  output logic                               out_degenerate
);
  import fdns_pkg::*;

  localparam int PRW = 2 * LW;
  localparam int TW  = PRW + 3;

  logic [8:0][COORD_WIDTH-1:0] v_in;
  logic        x_vld;
  side_t       x_side;
  logic        sq_vld_r, sum_vld_r;
  side_t       sq_side_r, sum_side_r;
  logic [SW-1:0] sq_r [3];
  logic [SW-1:0] sum_r;
  logic        rt_vld;
  logic [RW-1:0] rt_len;
  side_t       rt_side;
  logic [QW-1:0] q [3];
  logic [DIVL-1:0] dv_vld_r;
  logic [2:0]  dv_neg_r [DIVL];
  logic        dv_degen_r [DIVL];
  logic        n_vld_r, p_vld_r, t_vld_r;
  logic signed [LW-1:0] n_r [3];
  logic signed [LW-1:0] pn_r [3];
  logic signed [LW-1:0] tn_r [3];
  logic        n_degen_r, p_degen_r, t_degen_r;
  logic signed [PRW-1:0] prod_r [3];
  logic signed [TW-1:0]  t_r;
  logic signed [TW-1:0]  t_rnd;
  logic [15:0] shade_nxt;
  logic signed [LW-1:0] light_r [3];

  assign busy = 1'b0;
  assign v_in = {in_c_z, in_c_y, in_c_x, in_b_z, in_b_y, in_b_x, in_a_z, in_a_y, in_a_x};

  // Light direction registers; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_r[0] <= '0;
      light_r[1] <= '0;
      light_r[2] <= 16'sd16384;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_LIGHT_X: light_r[0] <= cfg_data;
        REG_LIGHT_Y: light_r[1] <= cfg_data;
        REG_LIGHT_Z: light_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  fdns_cross #(.CW(COORD_WIDTH)) u_cross (
    .clk(clk), .rst_n(rst_n), .vld_in(start && !busy), .v_in(v_in),
    .vld_out(x_vld), .side_out(x_side)
  );

  // Valid bits for the stages kept at the top level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r  <= 1'b0;
      sum_vld_r <= 1'b0;
      dv_vld_r  <= '0;
      n_vld_r   <= 1'b0;
      p_vld_r   <= 1'b0;
      t_vld_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      sq_vld_r  <= x_vld;
      sum_vld_r <= sq_vld_r;
      dv_vld_r  <= {dv_vld_r[DIVL-2:0], rt_vld};
      n_vld_r   <= dv_vld_r[DIVL-1];
      p_vld_r   <= n_vld_r;
      t_vld_r   <= p_vld_r;
      out_valid <= t_vld_r;
    end
  end

  // Squares of the normalized components, then their sum.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= SW'(x_side.m[i]) * SW'(x_side.m[i]);
    end
    sq_side_r  <= x_side;
    sum_r      <= sq_r[0] + sq_r[1] + sq_r[2];
    sum_side_r <= sq_side_r;
  end

  fdns_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .vld_in(sum_vld_r), .sum_in(sum_r), .side_in(sum_side_r),
    .vld_out(rt_vld), .root_out(rt_len), .side_out(rt_side)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    fdns_div u_div (.clk(clk), .m_in(rt_side.m[i]), .len_in(rt_len), .q_out(q[i]));
  end

  // Signs and the degenerate flag follow the dividers.
  always_ff @(posedge clk) begin
    dv_neg_r[0]   <= rt_side.neg;
    dv_degen_r[0] <= rt_side.degen;
    for (int k = 1; k < DIVL; k++) begin
      dv_neg_r[k]   <= dv_neg_r[k-1];
      dv_degen_r[k] <= dv_degen_r[k-1];
    end
  end

  // Apply signs; a degenerate triangle gives a zero normal.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (dv_degen_r[DIVL-1]) begin
        n_r[i] <= '0;
      end else if (dv_neg_r[DIVL-1][i]) begin
        n_r[i] <= -$signed({1'b0, q[i]});
      end else begin
        n_r[i] <= $signed({1'b0, q[i]});
      end
    end
    n_degen_r <= dv_degen_r[DIVL-1];
  end

  // Products with the light direction, then the biased dot product.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod_r[i] <= n_r[i] * light_r[i];
    end
    pn_r      <= n_r;
    p_degen_r <= n_degen_r;
    t_r <= (TW'(1) <<< 28) + TW'(prod_r[0]) + TW'(prod_r[1]) + TW'(prod_r[2]);
    tn_r      <= pn_r;
    t_degen_r <= p_degen_r;
  end

  // Round to unsigned Q1.15 and clamp to [0, 1].
  always_comb begin
    t_rnd = (t_r + TW'(ROUND_Q14)) >>> 14;
    if (t_r <= 0) begin
      shade_nxt = '0;
    end else if (t_rnd > TW'(ONE_Q15)) begin
      shade_nxt = 16'(ONE_Q15);
    end else begin
      shade_nxt = t_rnd[15:0];
    end
  end

  always_ff @(posedge clk) begin
    out_norm_x     <= tn_r[0];
    out_norm_y     <= tn_r[1];
    out_norm_z     <= tn_r[2];
    out_shade      <= shade_nxt;
    out_degenerate <= t_degen_r;
  end
endmodule
`default_nettype wire
